[hw/rtl/stsort_pkg.sv]
// Shared types and constants for the stable depth-key sorter.
// No dependencies; every other file in hw/rtl except stsort_ram refers to this package by scoped names.
package stsort_pkg;

    localparam int ID_W  = 8;
    localparam int KEY_W = 8;

    // Input command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SORT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store the input item, or flag overflow when full
        logic sort_start;  // clear the previous-output marker and output count
        logic pass_start;  // restart the scan address and clear the best entry
        logic rd_en;       // read the store at the scan address and advance it
        logic emit_done;   // the current result was transferred
    } stsort_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;  // the store is empty
        logic addr_last;   // the scan address points at the last stored entry
        logic out_last;    // the result being presented is the final one
    } stsort_sts_t;

endpackage

[hw/rtl/stsort_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module stsort_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/stsort_dp.sv]
// Datapath of the sorter: item store, fill count, overflow flag, scan address,
// and the best/previous entry registers of the selection pass. Uses stsort_pkg, stsort_ram.
module stsort_dp #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  stsort_pkg::stsort_cmd_t     cmd,
    output stsort_pkg::stsort_sts_t     sts,
    input  logic [stsort_pkg::ID_W-1:0] item_id,
    input  logic [stsort_pkg::KEY_W-1:0] pos_z,
    input  logic [stsort_pkg::KEY_W-1:0] layer_order,
    input  logic                        multi_position,
    output logic [stsort_pkg::ID_W-1:0] out_id,
    output logic [stsort_pkg::KEY_W-1:0] sort_key,
    output logic                        overflow
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W = stsort_pkg::ID_W + stsort_pkg::KEY_W;

    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic [IDX_W-1:0]             addr_reg, addr_next;
    logic                         rd_pend_reg;
    logic [IDX_W-1:0]             rd_idx_reg;
    logic                         best_valid_reg, best_valid_next;
    logic [stsort_pkg::KEY_W-1:0] best_key_reg, best_key_next;
    logic [stsort_pkg::ID_W-1:0]  best_id_reg, best_id_next;
    logic [IDX_W-1:0]             best_idx_reg, best_idx_next;
    logic                         prev_valid_reg, prev_valid_next;
    logic [stsort_pkg::KEY_W-1:0] prev_key_reg, prev_key_next;
    logic [IDX_W-1:0]             prev_idx_reg, prev_idx_next;
    logic [IDX_W-1:0]             out_cnt_reg, out_cnt_next;

    logic                         full;
    logic                         wr_en;
    logic [DATA_W-1:0]            wr_data;
    logic [DATA_W-1:0]            rd_data;
    logic [stsort_pkg::KEY_W-1:0] rd_key;
    logic [stsort_pkg::ID_W-1:0]  rd_id;
    logic                         cand;
    logic [CNT_W-1:0]             count_m1;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign wr_en    = cmd.load && !full;
    assign wr_data  = {item_id, (multi_position ? layer_order : pos_z)};
    assign rd_id    = rd_data[DATA_W-1:stsort_pkg::KEY_W];
    assign rd_key   = rd_data[stsort_pkg::KEY_W-1:0];
    assign count_m1 = count_reg - CNT_W'(1);

    stsort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    // An entry qualifies if it comes after the previously emitted one in
    // (key, load position) order; the scan keeps the smallest such entry.
    assign cand = !prev_valid_reg || (rd_key > prev_key_reg) ||
                  ((rd_key == prev_key_reg) && (rd_idx_reg > prev_idx_reg));

    always_comb begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        addr_next       = addr_reg;
        best_valid_next = best_valid_reg;
        best_key_next   = best_key_reg;
        best_id_next    = best_id_reg;
        best_idx_next   = best_idx_reg;
        prev_valid_next = prev_valid_reg;
        prev_key_next   = prev_key_reg;
        prev_idx_next   = prev_idx_reg;
        out_cnt_next    = out_cnt_reg;

        if (cmd.load) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.rd_en) begin
            addr_next = addr_reg + IDX_W'(1);
        end
        if (rd_pend_reg && cand && (!best_valid_reg || (rd_key < best_key_reg))) begin
            best_valid_next = 1'b1;
            best_key_next   = rd_key;
            best_id_next    = rd_id;
            best_idx_next   = rd_idx_reg;
        end
        if (cmd.pass_start) begin
            addr_next       = '0;
            best_valid_next = 1'b0;
        end
        if (cmd.emit_done) begin
            prev_valid_next = 1'b1;
            prev_key_next   = best_key_reg;
            prev_idx_next   = best_idx_reg;
            out_cnt_next    = out_cnt_reg + IDX_W'(1);
        end
        if (cmd.sort_start) begin
            prev_valid_next = 1'b0;
            out_cnt_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            rd_pend_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            addr_reg       <= '0;
            out_cnt_reg    <= '0;
        end else begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            rd_pend_reg    <= cmd.rd_en;
            best_valid_reg <= best_valid_next;
            prev_valid_reg <= prev_valid_next;
            addr_reg       <= addr_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg    <= addr_reg;
        best_key_reg  <= best_key_next;
        best_id_reg   <= best_id_next;
        best_idx_reg  <= best_idx_next;
        prev_key_reg  <= prev_key_next;
        prev_idx_reg  <= prev_idx_next;
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.addr_last  = (CNT_W'(addr_reg) == count_m1);
    assign sts.out_last   = (CNT_W'(out_cnt_reg) == count_m1);

    assign out_id   = best_id_reg;
    assign sort_key = best_key_reg;
    assign overflow = ovf_reg;

endmodule

[hw/rtl/stsort_ctrl.sv]
// Controller of the sorter: accepts loads and sort commands, sequences the
// selection passes and owns the result valid. Uses stsort_pkg.
module stsort_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_cmd,
    output logic                    m_valid,
    input  logic                    m_ready,
    output stsort_pkg::stsort_cmd_t cmd,
    input  stsort_pkg::stsort_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg;
        cmd            = '0;
        s_ready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd == stsort_pkg::CMD_LOAD) begin
                        cmd.load = 1'b1;
                    end else if (!sts.count_zero) begin
                        cmd.sort_start = 1'b1;
                        cmd.pass_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (sts.addr_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last read of the pass is compared in this cycle.
                m_valid_next = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    cmd.emit_done = 1'b1;
                    m_valid_next  = 1'b0;
                    if (sts.out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.pass_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default: begin
                m_valid_next = 1'b0;
                state_next   = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[hw/rtl/stable_sort_by_depth_key.sv]
// Stable sorter by depth key. A load transfer (cmd 0) stores one item and the block is ready
// again in the next cycle; a load into a full store is dropped and sets a sticky overflow flag
// that only reset clears. A sort transfer (cmd 1) emits every stored item in ascending key
// order, equal keys in load order, with last marking the final result; items stay stored, so
// later loads join the next sort. Each result costs one selection pass over the store through
// its single read port. A sort of an empty store gives no result. No new transfer is taken
// while a sort is running.
// Depends on stsort_pkg, stsort_ctrl, stsort_dp, stsort_ram.
module stable_sort_by_depth_key #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic [stsort_pkg::ID_W-1:0]  s_item_id,
    input  logic [stsort_pkg::KEY_W-1:0] s_pos_z,
    input  logic [stsort_pkg::KEY_W-1:0] s_layer_order,
    input  logic                         s_multi_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [stsort_pkg::ID_W-1:0]  m_out_id,
    output logic [stsort_pkg::KEY_W-1:0] m_sort_key,
    output logic                         m_last,
    output logic                         m_overflow
);

    stsort_pkg::stsort_cmd_t cmd;
    stsort_pkg::stsort_sts_t sts;

    stsort_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    stsort_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .item_id        (s_item_id),
        .pos_z          (s_pos_z),
        .layer_order    (s_layer_order),
        .multi_position (s_multi_position),
        .out_id         (m_out_id),
        .sort_key       (m_sort_key),
        .overflow       (m_overflow)
    );

    assign m_last = sts.out_last;

endmodule

[verif/tb_stable_sort_by_depth_key.sv]
// Self-checking testbench for stable_sort_by_depth_key: random and directed load and sort
// transfers, with a scoreboard class that predicts the stable key order and checks each result.
// Depends on stsort_pkg and the stable_sort_by_depth_key RTL.
`timescale 1ns / 1ps

module tb_stable_sort_by_depth_key;

    localparam int QUEUE_DEPTH = 32;
    localparam int RUN_LIMIT   = 5_000_000;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 300;

    typedef logic [stsort_pkg::ID_W-1:0]  id_t;
    typedef logic [stsort_pkg::KEY_W-1:0] key_t;

    typedef struct packed {
        id_t  id;
        key_t key;
        logic last;
        logic overflow;
    } emit_t;

    // Tracks the stored items in load order, replays the stable sort on each sort
    // transfer and holds the results that the block still owes.
    class depth_sort_scoreboard;
        id_t         stored_id[$];
        key_t        stored_key[$];
        logic        overflow_seen;
        emit_t       awaited_emits[$];
        int unsigned errors;
        int unsigned results_checked;

        function new();
            overflow_seen   = 1'b0;
            errors          = 0;
            results_checked = 0;
        endfunction

        function void note_transfer(logic cmd, id_t id, key_t pos_z, key_t layer, logic multi);
            key_t  k;
            id_t   d;
            int    i;
            int    j;
            emit_t e;
            if (cmd == stsort_pkg::CMD_LOAD) begin
                if (stored_key.size() < QUEUE_DEPTH) begin
                    stored_id.insert(stored_id.size(), id);
                    stored_key.insert(stored_key.size(), multi ? layer : pos_z);
                end else begin
                    overflow_seen = 1'b1;
                end
                return;
            end
            // Insertion sort keeps equal keys in load order; the store stays sorted.
            for (i = 1; i < stored_key.size(); i++) begin
                k = stored_key[i];
                d = stored_id[i];
                j = i;
                while (j > 0 && stored_key[j-1] > k) begin
                    stored_key[j] = stored_key[j-1];
                    stored_id[j]  = stored_id[j-1];
                    j--;
                end
                stored_key[j] = k;
                stored_id[j]  = d;
            end
            for (i = 0; i < stored_key.size(); i++) begin
                e.id       = stored_id[i];
                e.key      = stored_key[i];
                e.last     = (i == stored_key.size() - 1);
                e.overflow = overflow_seen;
                awaited_emits.insert(awaited_emits.size(), e);
            end
        endfunction

        function void check_emit(id_t id, key_t key, logic last_flag, logic ovf);
            emit_t want;
            results_checked++;
            if (awaited_emits.size() == 0) begin
                $error("unexpected result: out_id %0d sort_key %0d last %0b", id, key, last_flag);
                errors++;
                return;
            end
            want = awaited_emits[0];
            awaited_emits.delete(0);
            if (id !== want.id) begin
                $error("out_id mismatch: expected %0d, got %0d", want.id, id);
                errors++;
            end
            if (key !== want.key) begin
                $error("sort_key mismatch: expected %0d, got %0d", want.key, key);
                errors++;
            end
            if (last_flag !== want.last) begin
                $error("last mismatch: expected %0b, got %0b", want.last, last_flag);
                errors++;
            end
            if (ovf !== want.overflow) begin
                $error("overflow mismatch: expected %0b, got %0b", want.overflow, ovf);
                errors++;
            end
        endfunction
    endclass

    logic aclk             = 1'b0;
    logic aresetn          = 1'b0;
    logic s_valid          = 1'b0;
    logic s_ready;
    logic s_cmd            = 1'b0;
    id_t  s_item_id        = '0;
    key_t s_pos_z          = '0;
    key_t s_layer_order    = '0;
    logic s_multi_position = 1'b0;
    logic m_valid;
    logic m_ready          = 1'b0;
    id_t  m_out_id;
    key_t m_sort_key;
    logic m_last;
    logic m_overflow;

    bit tail_calm = 1'b0;
    depth_sort_scoreboard board = new();

    stable_sort_by_depth_key #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_item_id        (s_item_id),
        .s_pos_z          (s_pos_z),
        .s_layer_order    (s_layer_order),
        .s_multi_position (s_multi_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_id         (m_out_id),
        .m_sort_key       (m_sort_key),
        .m_last           (m_last),
        .m_overflow       (m_overflow)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offers one item and returns at the edge where it transfers, leaving valid high
    // unless a random gap follows.
    task automatic send_item(logic cmd, id_t id, key_t pos_z, key_t layer, logic multi);
        s_valid          <= 1'b1;
        s_cmd            <= cmd;
        s_item_id        <= id;
        s_pos_z          <= pos_z;
        s_layer_order    <= layer;
        s_multi_position <= multi;
        do @(posedge aclk); while (!s_ready);
        board.note_transfer(cmd, id, pos_z, layer, multi);
        if (!tail_calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    function automatic key_t draw_key();
        // Half the keys come from a narrow range so that ties are common.
        return $urandom_range(0, 1) ? key_t'($urandom_range(0, 3)) : key_t'($urandom_range(0, 255));
    endfunction

    initial begin : stimulus
        int unsigned counted;
        bit          full_sorted;
        bit          do_sort;
        counted     = 0;
        full_sorted = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty store, extreme ids and keys, both key selections and ties.
        send_item(stsort_pkg::CMD_SORT, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(stsort_pkg::CMD_LOAD, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_item(stsort_pkg::CMD_LOAD, 8'hFF, 8'h00, 8'hFF, 1'b1);
        send_item(stsort_pkg::CMD_LOAD, 8'h5A, 8'h00, 8'h80, 1'b0);
        send_item(stsort_pkg::CMD_LOAD, 8'hA5, 8'hFF, 8'h00, 1'b1);
        send_item(stsort_pkg::CMD_LOAD, 8'h33, 8'h10, 8'h77, 1'b0);
        send_item(stsort_pkg::CMD_SORT, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(stsort_pkg::CMD_LOAD, 8'h11, 8'hEE, 8'h10, 1'b1);
        send_item(stsort_pkg::CMD_LOAD, 8'hEE, 8'h00, 8'h42, 1'b0);
        send_item(stsort_pkg::CMD_SORT, 8'h12, 8'h34, 8'h56, 1'b0);

        while (counted < 440) begin
            if (board.stored_key.size() == QUEUE_DEPTH && !full_sorted) begin
                // Sort a full store once before any load overflows it.
                do_sort     = 1'b1;
                full_sorted = 1'b1;
            end else if (board.stored_key.size() < QUEUE_DEPTH) begin
                do_sort = ($urandom_range(0, 9) < 3);
            end else begin
                do_sort = ($urandom_range(0, 99) < 88);
            end
            // Loads into a full store are dropped, so they do not count.
            if (do_sort || board.stored_key.size() < QUEUE_DEPTH) begin
                counted++;
            end
            if (counted >= 400) begin
                tail_calm = 1'b1;
            end
            send_item(do_sort ? stsort_pkg::CMD_SORT : stsort_pkg::CMD_LOAD,
                      id_t'($urandom_range(0, 255)), draw_key(), draw_key(),
                      logic'($urandom_range(0, 1)));
        end
        s_valid <= 1'b0;

        while (board.awaited_emits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned stall_left;
        int unsigned calm_left;
        bit          held;
        stall_left = 0;
        calm_left  = 0;
        held       = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                board.check_emit(m_out_id, m_sort_key, m_last, m_overflow);
            end
            if (!held && board.results_checked >= 40) begin
                // Long hold-off mid-sort so the block backs up into its input.
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (tail_calm) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (calm_left > 0) begin
                m_ready <= 1'b1;
                calm_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(1, 15) - 1;
                calm_left  = $urandom_range(0, 1) ? $urandom_range(20, 120) : 0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= RUN_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
hw/rtl/stsort_pkg.sv
hw/rtl/stsort_ram.sv
hw/rtl/stsort_dp.sv
hw/rtl/stsort_ctrl.sv
hw/rtl/stable_sort_by_depth_key.sv
verif/tb_stable_sort_by_depth_key.sv
